FILE: design/ers_pkg.sv
// Shared types, constants and widths of the edge row SSD top-three matcher.
`timescale 1ns / 1ps

package ers_pkg;

    localparam int ROW_PIXELS_DEF = 512;
    localparam int PIX_IDX_W      = 9;
    localparam int COLOR_W        = 24;
    localparam int ID_W           = 17;
    localparam int DIFF_W         = 27;
    localparam int SQ_W           = 16;

    localparam logic [DIFF_W-1:0] SENTINEL_DIFF   = DIFF_W'(100000000);
    localparam logic [DIFF_W-1:0] THRESHOLD_RESET = DIFF_W'(8000);
    localparam logic [DIFF_W-1:0] DIFF_MAX        = {DIFF_W{1'b1}};

    typedef enum logic {
        OP_LOAD    = 1'b0,
        OP_COMPARE = 1'b1
    } t_op;

    typedef struct packed {
        t_op                  op;
        logic [PIX_IDX_W-1:0] pixel_index;
        logic [COLOR_W-1:0]   pixel_color;
        logic [ID_W-1:0]      item_id;
        logic                 last_pixel;
        logic                 last_candidate;
    } t_in_beat;

    typedef struct packed {
        logic [ID_W-1:0]   candidate_id;
        logic [DIFF_W-1:0] candidate_diff;
        logic              exceeds_threshold;
        logic [ID_W-1:0]   best_id;
        logic [DIFF_W-1:0] best_sum;
        logic [ID_W-1:0]   second_id;
        logic [DIFF_W-1:0] second_sum;
        logic [ID_W-1:0]   third_id;
        logic [DIFF_W-1:0] third_sum;
        logic              self_match;
        logic              final_res;
    } t_out_beat;

    // What one ranking cell hands to its right-hand neighbor.
    typedef struct packed {
        logic              lt;
        logic [ID_W-1:0]   id;
        logic [DIFF_W-1:0] diff;
    } t_rank_link;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_ACCUM,
        ST_RANK,
        ST_EMIT
    } t_state;

endpackage

FILE: design/ers_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module ers_ram #(
    parameter  int WIDTH = 8,
    parameter  int DEPTH = 16,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: design/ers_cost.sv
// Per-pixel cost stage: registered squares of the three channel differences.
`timescale 1ns / 1ps

module ers_cost (
    input  logic                                        i_clk,
    input  logic                                        i_en,
    input  logic [ers_pkg::COLOR_W-1:0]                 i_query,
    input  logic [ers_pkg::COLOR_W-1:0]                 i_cand,
    output logic [2:0][ers_pkg::SQ_W-1:0]               o_sq
);
    import ers_pkg::*;

    logic [2:0][SQ_W-1:0] r_sq;
    logic [2:0][SQ_W-1:0] n_sq;

    always_comb begin
        logic [7:0] a;
        logic [7:0] b;
        logic [7:0] d;
        for (int c = 0; c < 3; c++) begin
            a = i_query[c*8 +: 8];
            b = i_cand[c*8 +: 8];
            d = (a > b) ? (a - b) : (b - a);
            n_sq[c] = SQ_W'(d) * SQ_W'(d);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sq <= n_sq;
        end
    end

    assign o_sq = r_sq;

endmodule

FILE: design/ers_rank_cell.sv
// One slot of the ranked best-three chain; shifts toward the right on insert.
`timescale 1ns / 1ps

module ers_rank_cell (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_clear,
    input  logic [ers_pkg::ID_W-1:0]     i_clear_id,
    input  logic                         i_insert,
    input  logic [ers_pkg::ID_W-1:0]     i_cand_id,
    input  logic [ers_pkg::DIFF_W-1:0]   i_cand_diff,
    input  ers_pkg::t_rank_link          i_left,
    output ers_pkg::t_rank_link          o_right
);
    import ers_pkg::*;

    logic [ID_W-1:0]   r_id;
    logic [DIFF_W-1:0] r_diff;
    logic              lt;

    assign lt = (i_cand_diff < r_diff);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_id   <= '0;
            r_diff <= SENTINEL_DIFF;
        end else if (i_clear) begin
            r_id   <= i_clear_id;
            r_diff <= SENTINEL_DIFF;
        end else if (i_insert && lt) begin
            // The slot to the left also lost to the candidate: take its old entry.
            if (i_left.lt) begin
                r_id   <= i_left.id;
                r_diff <= i_left.diff;
            end else begin
                r_id   <= i_cand_id;
                r_diff <= i_cand_diff;
            end
        end
    end

    assign o_right = '{lt: lt, id: r_id, diff: r_diff};

endmodule

FILE: design/edge_row_ssd_top3_match.sv
// Top level of the edge row SSD matcher with a ranked best-three of candidates.
// A query-load beat is taken in the idle state. A candidate pixel that is not the last of its
// row passes the accept with query RAM read, the square stage and the accumulate step.
// A last pixel then also passes the ranking step and the emit state, which loads its
// result into the output register and waits while that register still holds an
// untaken result. Reset is synchronous, active low; it clears FSM, running sum,
// ranking, query id, output valid, threshold to 8000.
`timescale 1ns / 1ps

module edge_row_ssd_top3_match #(
    parameter int ROW_PIXELS = ers_pkg::ROW_PIXELS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [ers_pkg::DIFF_W-1:0]   i_cfg_wdata,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  ers_pkg::t_in_beat            i_in,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output ers_pkg::t_out_beat           o_out
);
    import ers_pkg::*;

    // Address width of the query row store and a common width to compare indexes in.
    localparam int AW = (ROW_PIXELS > 1) ? $clog2(ROW_PIXELS) : 1;
    localparam int XW = (AW > PIX_IDX_W) ? AW : PIX_IDX_W;

    // Control outputs of the sequencer, grouped.
    typedef struct packed {
        logic in_ready;
        logic ram_we;
        logic ram_re;
        logic cost_en;
        logic accum;
        logic rank_insert;
        logic out_load;
        logic clear_load;
        logic clear_final;
    } t_ctrl;

    t_state            r_state;
    t_state            n_state;
    t_ctrl             ctrl;

    logic [DIFF_W-1:0] r_threshold;
    logic [ID_W-1:0]   r_query_id;
    logic [DIFF_W-1:0] r_sum;
    logic [DIFF_W-1:0] n_sum;
    t_in_beat          r_item;
    logic              r_in_range;
    logic              r_out_valid;
    t_out_beat         r_out;

    logic              accept;
    logic              in_range;
    logic [XW-1:0]     idx_x;
    logic [AW-1:0]     addr;
    logic [COLOR_W-1:0] query_pix;
    logic [2:0][SQ_W-1:0] sq;
    logic [DIFF_W:0]   sum_wide;
    logic              out_free;
    logic              rank_clear;
    logic [ID_W-1:0]   rank_clear_id;
    t_rank_link        link [4];

    assign accept   = i_in_valid && ctrl.in_ready;
    assign idx_x    = XW'(i_in.pixel_index);
    assign addr     = idx_x[AW-1:0];
    assign in_range = (32'(i_in.pixel_index) < ROW_PIXELS);
    assign out_free = !r_out_valid || i_out_ready;

    // ---------------------------------------------------------------- sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid && (i_in.op == OP_COMPARE)) begin
                    n_state = ST_SQUARE;
                end
            end
            ST_SQUARE: n_state = ST_ACCUM;
            ST_ACCUM:  n_state = r_item.last_pixel ? ST_RANK : ST_IDLE;
            ST_RANK:   n_state = ST_EMIT;
            ST_EMIT: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default:   n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        ctrl = '0;
        unique case (r_state)
            ST_IDLE: begin
                ctrl.in_ready   = 1'b1;
                ctrl.ram_we     = i_in_valid && (i_in.op == OP_LOAD) && in_range;
                ctrl.ram_re     = i_in_valid && (i_in.op == OP_COMPARE);
                ctrl.clear_load = i_in_valid && (i_in.op == OP_LOAD);
            end
            ST_SQUARE: ctrl.cost_en     = 1'b1;
            ST_ACCUM:  ctrl.accum       = 1'b1;
            ST_RANK:   ctrl.rank_insert = 1'b1;
            ST_EMIT: begin
                ctrl.out_load    = out_free;
                ctrl.clear_final = out_free && r_item.last_candidate;
            end
            default: ctrl = '0;
        endcase
    end

    // ---------------------------------------------------------- configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= THRESHOLD_RESET;
        end else if (i_cfg_we) begin
            r_threshold <= i_cfg_wdata;
        end
    end

    // ---------------------------------------------------------- query storage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_query_id <= '0;
        end else if (ctrl.clear_load) begin
            r_query_id <= i_in.item_id;
        end
    end

    ers_ram #(
        .WIDTH (COLOR_W),
        .DEPTH (ROW_PIXELS)
    ) u_query_row (
        .i_clk   (i_clk),
        .i_we    (ctrl.ram_we),
        .i_waddr (addr),
        .i_wdata (i_in.pixel_color),
        .i_re    (ctrl.ram_re),
        .i_raddr (addr),
        .o_rdata (query_pix)
    );

    // The accepted beat is held while the candidate pixel works its way through.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item     <= i_in;
            r_in_range <= in_range;
        end
    end

    // ------------------------------------------------------- cost and running sum
    ers_cost u_cost (
        .i_clk   (i_clk),
        .i_en    (ctrl.cost_en),
        .i_query (query_pix),
        .i_cand  (r_item.pixel_color),
        .o_sq    (sq)
    );

    // The sum saturates at the all-ones value of its width.
    assign sum_wide = (DIFF_W+1)'(r_sum) + (DIFF_W+1)'(sq[0])
                    + (DIFF_W+1)'(sq[1]) + (DIFF_W+1)'(sq[2]);

    always_comb begin
        n_sum = r_sum;
        if (ctrl.clear_load || ctrl.out_load) begin
            n_sum = '0;
        end else if (ctrl.accum && r_in_range) begin
            n_sum = sum_wide[DIFF_W] ? DIFF_MAX : sum_wide[DIFF_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
        end else begin
            r_sum <= n_sum;
        end
    end

    // ------------------------------------------------------------ ranking chain
    // A query load resets the slots to the new id, a final result to the stored one.
    assign rank_clear    = ctrl.clear_load || ctrl.clear_final;
    assign rank_clear_id = ctrl.clear_load ? i_in.item_id : r_query_id;
    assign link[0]       = '{lt: 1'b0, id: '0, diff: '0};

    for (genvar k = 0; k < 3; k++) begin : g_rank
        ers_rank_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_clear     (rank_clear),
            .i_clear_id  (rank_clear_id),
            .i_insert    (ctrl.rank_insert),
            .i_cand_id   (r_item.item_id),
            .i_cand_diff (r_sum),
            .i_left      (link[k]),
            .o_right     (link[k+1])
        );
    end

    // ------------------------------------------------------------ result register
    // The result captures the ranking after this candidate's insert and before any
    // final reset of the slots, which happens at the same edge.
    always_ff @(posedge i_clk) begin
        if (ctrl.out_load) begin
            r_out.candidate_id      <= r_item.item_id;
            r_out.candidate_diff    <= r_sum;
            r_out.exceeds_threshold <= (r_sum > r_threshold);
            r_out.best_id           <= link[1].id;
            r_out.best_sum          <= link[1].diff;
            r_out.second_id         <= link[2].id;
            r_out.second_sum        <= link[2].diff;
            r_out.third_id          <= link[3].id;
            r_out.third_sum         <= link[3].diff;
            r_out.self_match        <= r_item.last_candidate && (link[1].id == r_query_id);
            r_out.final_res         <= r_item.last_candidate;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctrl.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_in_ready  = ctrl.in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // ------------------------------------------------------------------ checks
    a_rank_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (link[1].diff <= link[2].diff) && (link[2].diff <= link[3].diff))
        else $error("ranking slots out of order");

    a_self_needs_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.self_match) |-> r_out.final_res)
        else $error("self match flagged on a result that is not final");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctrl.out_load |-> (!r_out_valid || i_out_ready))
        else $error("result register loaded while holding an untaken beat");

    a_final_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctrl.clear_final |=> (link[1].diff == SENTINEL_DIFF) && (r_sum == '0))
        else $error("ranking or sum not reset after a final result");

endmodule

FILE: dv/tb_top.sv
// Self-checking testbench for the edge row SSD top-three matcher.
`timescale 1ns / 1ps

module tb_top;
    import ers_pkg::*;

    localparam int ROW_LEN       = ROW_PIXELS_DEF;
    localparam int SETTLE_CYCLES = 12;
    localparam int RANDOM_BEATS  = 330;
    localparam int PRINT_CAP     = 40;

    // How a candidate pixel color relates to the stored query pixel.
    typedef enum int {
        COL_RANDOM,
        COL_EXACT,
        COL_NEAR,
        COL_PALETTE
    } t_color_mode;

    // Output-side back-pressure patterns.
    typedef enum int {
        RX_ALWAYS,
        RX_COIN,
        RX_QUARTER,
        RX_BURSTY
    } t_rx_mode;

    // Keeps its own copy of the query row, the running sum and the ranked best three,
    // turns every accepted input beat into the result it should cause, and holds those
    // results in order until the block delivers them.
    class ssd_rank_tracker;
        logic [COLOR_W-1:0] query_pix [ROW_LEN];
        logic [ID_W-1:0]    query_id;
        logic [DIFF_W-1:0]  run_sum;
        logic [DIFF_W-1:0]  threshold;
        logic [ID_W-1:0]    top_id [3];
        logic [DIFF_W-1:0]  top_diff [3];
        t_out_beat          pending_results [$];
        int                 mismatches;
        int                 results_seen;

        function new();
            threshold    = THRESHOLD_RESET;
            query_id     = '0;
            run_sum      = '0;
            mismatches   = 0;
            results_seen = 0;
            foreach (query_pix[i]) query_pix[i] = '0;
            reset_ranking();
        endfunction

        function void reset_ranking();
            for (int k = 0; k < 3; k++) begin
                top_id[k]   = query_id;
                top_diff[k] = SENTINEL_DIFF;
            end
        endfunction

        function void set_threshold(logic [DIFF_W-1:0] value);
            threshold = value;
        endfunction

        function int unsigned chan_sq(logic [7:0] a, logic [7:0] b);
            int unsigned d;
            d = (a > b) ? a - b : b - a;
            return d * d;
        endfunction

        function int unsigned pixel_cost(logic [COLOR_W-1:0] q, logic [COLOR_W-1:0] c);
            return chan_sq(q[23:16], c[23:16]) + chan_sq(q[15:8], c[15:8])
                 + chan_sq(q[7:0], c[7:0]);
        endfunction

        // Strict less-than: an equal sum never displaces an earlier candidate.
        function void insert_rank(logic [ID_W-1:0] id, logic [DIFF_W-1:0] diff);
            if (diff < top_diff[0]) begin
                top_id[2]   = top_id[1];
                top_diff[2] = top_diff[1];
                top_id[1]   = top_id[0];
                top_diff[1] = top_diff[0];
                top_id[0]   = id;
                top_diff[0] = diff;
            end else if (diff < top_diff[1]) begin
                top_id[2]   = top_id[1];
                top_diff[2] = top_diff[1];
                top_id[1]   = id;
                top_diff[1] = diff;
            end else if (diff < top_diff[2]) begin
                top_id[2]   = id;
                top_diff[2] = diff;
            end
        endfunction

        function void take_beat(t_in_beat b);
            int unsigned sum;
            t_out_beat   r;
            if (b.op == OP_LOAD) begin
                query_pix[b.pixel_index] = b.pixel_color;
                query_id = b.item_id;
                run_sum  = '0;
                reset_ranking();
                return;
            end
            sum = run_sum + pixel_cost(query_pix[b.pixel_index], b.pixel_color);
            run_sum = (sum > DIFF_MAX) ? DIFF_MAX : sum[DIFF_W-1:0];
            if (!b.last_pixel) return;
            insert_rank(b.item_id, run_sum);
            r.candidate_id      = b.item_id;
            r.candidate_diff    = run_sum;
            r.exceeds_threshold = (run_sum > threshold);
            r.best_id           = top_id[0];
            r.best_sum          = top_diff[0];
            r.second_id         = top_id[1];
            r.second_sum        = top_diff[1];
            r.third_id          = top_id[2];
            r.third_sum         = top_diff[2];
            r.self_match        = b.last_candidate && (top_id[0] == query_id);
            r.final_res         = b.last_candidate;
            pending_results.insert(pending_results.size(), r);
            run_sum = '0;
            if (b.last_candidate) reset_ranking();
        endfunction

        function int outstanding();
            return pending_results.size();
        endfunction

        task report_mismatch(string msg);
            mismatches++;
            if (mismatches <= PRINT_CAP) $display("mismatch: %s", msg);
        endtask

        task compare_field(string name, logic [31:0] got, logic [31:0] want);
            if (got !== want)
                report_mismatch($sformatf("result %0d %s: got %0d, expected %0d",
                                          results_seen, name, got, want));
        endtask

        task check_result(t_out_beat got);
            t_out_beat want;
            results_seen++;
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("result %0d arrived with nothing expected",
                                          results_seen));
                return;
            end
            want = pending_results.pop_front();
            compare_field("candidate_id", got.candidate_id, want.candidate_id);
            compare_field("candidate_diff", got.candidate_diff, want.candidate_diff);
            compare_field("exceeds_threshold", got.exceeds_threshold, want.exceeds_threshold);
            compare_field("best_id", got.best_id, want.best_id);
            compare_field("best_sum", got.best_sum, want.best_sum);
            compare_field("second_id", got.second_id, want.second_id);
            compare_field("second_sum", got.second_sum, want.second_sum);
            compare_field("third_id", got.third_id, want.third_id);
            compare_field("third_sum", got.third_sum, want.third_sum);
            compare_field("self_match", got.self_match, want.self_match);
            compare_field("final_res", got.final_res, want.final_res);
        endtask
    endclass

    // Every input of the block starts at a known value; reset is held from time zero.
    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              cfg_we    = 1'b0;
    logic [DIFF_W-1:0] cfg_wdata = '0;
    logic              in_valid  = 1'b0;
    logic              in_ready;
    t_in_beat          in_beat   = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    t_out_beat         out_beat;

    ssd_rank_tracker tracker;

    // What the stimulus side knows about the query row. Candidates only ever read
    // positions that a load has written, since unwritten entries have no defined value.
    logic [COLOR_W-1:0] row_color [ROW_LEN];
    bit                 row_loaded [ROW_LEN];
    int unsigned        loaded_idx [$];
    logic [ID_W-1:0]    active_query = '0;
    logic [ID_W-1:0]    prev_cand_id = '0;
    int                 beats_sent   = 0;
    int                 burst_left   = 0;

    t_rx_mode rx_mode = RX_ALWAYS;
    int       rx_tick = 0;
    int       rx_hold = 0;

    edge_row_ssd_top3_match uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_beat),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_beat)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Output side. A beat is taken at an edge where valid and ready were both high
    // just before it; the ready for the next edge is then chosen by the current
    // back-pressure pattern, which the tick counter itself periodically redraws at random.
    always @(posedge clk) begin
        if (out_valid === 1'b1 && out_ready) tracker.check_result(out_beat);
        rx_tick++;
        if (rx_tick % 101 == 0) rx_mode = t_rx_mode'($urandom_range(0, 3));
        case (rx_mode)
            RX_ALWAYS: out_ready <= 1'b1;
            RX_COIN: out_ready <= ($urandom_range(0, 1) != 0);
            RX_QUARTER: out_ready <= (rx_tick % 4 == 0);
            default: begin
                if (rx_hold > 0) begin
                    out_ready <= 1'b0;
                    rx_hold--;
                end else begin
                    out_ready <= 1'b1;
                    if ($urandom_range(0, 5) == 0) rx_hold = $urandom_range(4, 16);
                end
            end
        endcase
    end

    // Offers one input beat and returns in the time step of its acceptance. The
    // sender works in bursts: inside a burst valid stays high from beat to beat, and
    // each new burst starts after a gap with valid low, so valid is never lowered and
    // raised in the same step.
    task automatic send_beat(input t_in_beat b);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 4) == 0) ? $urandom_range(4, 12) : $urandom_range(1, 3);
            repeat (gap) @(posedge clk);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
        end
        in_valid <= 1'b1;
        in_beat  <= b;
        do @(posedge clk); while (in_ready !== 1'b1);
        tracker.take_beat(b);
        beats_sent++;
        burst_left--;
        if (burst_left == 0) in_valid <= 1'b0;
    endtask

    // Ends the current burst early; called in the step of the last acceptance.
    task automatic hold_input();
        if (burst_left != 0) begin
            in_valid   <= 1'b0;
            burst_left = 0;
        end
    endtask

    // Stops sending until every expected beat has come out, then lets the pipeline
    // empty of beats that cause no result.
    task automatic wait_drained();
        hold_input();
        while (tracker.outstanding() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Only called while the block is idle.
    task automatic write_threshold(input logic [DIFF_W-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        tracker.set_threshold(value);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic load_pixel(input logic [PIX_IDX_W-1:0] idx,
                              input logic [COLOR_W-1:0] color,
                              input logic [ID_W-1:0] id, input logic lp, input logic lc);
        t_in_beat b;
        b.op             = OP_LOAD;
        b.pixel_index    = idx;
        b.pixel_color    = color;
        b.item_id        = id;
        b.last_pixel     = lp;
        b.last_candidate = lc;
        if (!row_loaded[idx]) begin
            row_loaded[idx] = 1'b1;
            loaded_idx.insert(loaded_idx.size(), idx);
        end
        row_color[idx] = color;
        active_query   = id;
        send_beat(b);
    endtask

    task automatic cand_pixel(input logic [PIX_IDX_W-1:0] idx,
                              input logic [COLOR_W-1:0] color,
                              input logic [ID_W-1:0] id, input logic lp, input logic lc);
        t_in_beat b;
        b.op             = OP_COMPARE;
        b.pixel_index    = idx;
        b.pixel_color    = color;
        b.item_id        = id;
        b.last_pixel     = lp;
        b.last_candidate = lc;
        prev_cand_id     = id;
        send_beat(b);
    endtask

    function automatic logic [COLOR_W-1:0] cand_color(int unsigned idx, t_color_mode mode);
        case (mode)
            COL_EXACT: return row_color[idx];
            COL_NEAR: return row_color[idx] ^ COLOR_W'($urandom & 32'h0007_0707);
            COL_PALETTE: return ($urandom_range(0, 1) != 0) ? 24'hFF_FFFF : 24'h00_0000;
            default: return COLOR_W'($urandom);
        endcase
    endfunction

    // One candidate row over positions already loaded. Stray last_candidate flags on
    // pixels that are not the row's last one must be ignored by the block.
    task automatic send_candidate(input logic [ID_W-1:0] id, input int npix,
                                  input t_color_mode mode, input logic lc);
        int unsigned idx;
        logic        lc_here;
        for (int p = 0; p < npix; p++) begin
            idx     = loaded_idx[$urandom_range(0, loaded_idx.size() - 1)];
            lc_here = (p == npix - 1) ? lc : logic'($urandom_range(0, 7) == 0);
            cand_pixel(idx[PIX_IDX_W-1:0], cand_color(idx, mode), id, p == npix - 1,
                       lc_here);
        end
    endtask

    // A new query of a few pixels. The row keeps earlier pixels, so loaded positions
    // only grow. Flags on load beats carry no meaning and are randomized.
    task automatic start_query();
        logic [ID_W-1:0] id;
        int              nload;
        nload = $urandom_range(1, 6);
        id    = ($urandom_range(0, 3) == 0) ? ID_W'($urandom_range(0, 7)) : ID_W'($urandom);
        repeat (nload)
            load_pixel(PIX_IDX_W'($urandom), COLOR_W'($urandom), id,
                       logic'($urandom_range(0, 1)), logic'($urandom_range(0, 1)));
    endtask

    // Mostly thresholds in the range that short random rows reach, plus the extremes
    // and the reset value.
    function automatic logic [DIFF_W-1:0] pick_threshold();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return SENTINEL_DIFF;
            2: return DIFF_W'($urandom_range(0, 100000000));
            3: return THRESHOLD_RESET;
            default: return DIFF_W'($urandom_range(0, 400000));
        endcase
    endfunction

    initial begin
        int              groups;
        int              ncand;
        int              npix;
        int              rand_start;
        logic            lc;
        logic            need_load;
        logic [ID_W-1:0] cid;
        int unsigned     idx;

        tracker = new();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // With a zero threshold, a zero sum does not exceed it and a sum of one does.
        write_threshold('0);

        // Directed part. The query row gets both ends of the index range and both
        // color extremes; the last load fixes the query id at the top of its range.
        load_pixel(9'd0,   24'h00_0000, 17'd0, 1'b0, 1'b0);
        load_pixel(9'd511, 24'hFF_FFFF, 17'd0, 1'b1, 1'b1);
        load_pixel(9'h155, 24'hAA_AAAA, 17'd0, 1'b0, 1'b0);
        load_pixel(9'h0AA, 24'h55_5555, 17'd0, 1'b0, 1'b1);
        load_pixel(9'h100, 24'h12_3456, 17'h1_FFFF, 1'b0, 1'b0);
        // Largest single-pixel difference lands in the best slot.
        cand_pixel(9'd0, 24'hFF_FFFF, 17'd5, 1'b1, 1'b0);
        // The query itself as a candidate: a two-pixel row with a zero sum.
        cand_pixel(9'd511, 24'hFF_FFFF, 17'h1_FFFF, 1'b0, 1'b0);
        cand_pixel(9'd0,   24'h00_0000, 17'h1_FFFF, 1'b1, 1'b0);
        // An equal zero sum later on must stay behind the earlier one.
        cand_pixel(9'd511, 24'hFF_FFFF, 17'd7, 1'b1, 1'b0);
        cand_pixel(9'h155, 24'hAA_AAAB, 17'd0, 1'b1, 1'b0);
        // Last candidate, with the flag also set on a pixel before the row's end;
        // the best id is the query id, so this final result is a self-match.
        cand_pixel(9'h0AA, 24'h56_5554, 17'd9, 1'b0, 1'b1);
        cand_pixel(9'h100, 24'h12_3456, 17'd9, 1'b1, 1'b1);
        // The ranking starts over after the final result.
        cand_pixel(9'h155, 24'h55_AA00, 17'd3, 1'b1, 1'b1);
        // A candidate cut short by a query load: its partial sum must be dropped.
        cand_pixel(9'h0AA, 24'h00_0000, 17'd12, 1'b0, 1'b0);
        load_pixel(9'h1C3, 24'h0F_0F0F, 17'h0_AAAA, 1'b0, 1'b0);
        cand_pixel(9'h1C3, 24'h0F_0F0F, 17'h1_5555, 1'b1, 1'b0);
        cand_pixel(9'h155, 24'hAA_AAAA, 17'h1_5555, 1'b1, 1'b1);

        // A long row against the top threshold. It overflows the 27-bit sum and must
        // saturate; with no candidate below the sentinel, every slot still holds the
        // query id, which makes the final result a self-match.
        wait_drained();
        write_threshold(SENTINEL_DIFF);
        load_pixel(9'd0, 24'h00_0000, ID_W'($urandom), 1'b0, 1'b0);
        for (int p = 0; p < 700; p++)
            cand_pixel(9'd0, 24'hFF_FFFF, 17'h0_1234, p == 699, p == 699);

        // Random part: mostly well-formed query groups with random content, some
        // groups that run on without a reload or without a final candidate, and some
        // candidates broken off by a load. Every twelfth group the sender drains the
        // block completely and the threshold changes.
        wait_drained();
        write_threshold(pick_threshold());
        rand_start = beats_sent;
        groups     = 0;
        need_load  = 1'b1;
        while (beats_sent < rand_start + RANDOM_BEATS) begin
            if (groups % 12 == 11) begin
                wait_drained();
                write_threshold(pick_threshold());
            end
            if (need_load || $urandom_range(0, 3) != 0) start_query();
            need_load = 1'b0;
            ncand = $urandom_range(1, 6);
            for (int c = 0; c < ncand; c++) begin
                case ($urandom_range(0, 5))
                    0: cid = active_query;
                    1: cid = prev_cand_id;
                    default: cid = ID_W'($urandom);
                endcase
                npix = ($urandom_range(0, 19) == 0) ? $urandom_range(9, 40)
                                                    : $urandom_range(1, 8);
                lc   = (c == ncand - 1) ? logic'($urandom_range(0, 9) != 0)
                                        : logic'($urandom_range(0, 19) == 0);
                send_candidate(cid, npix, t_color_mode'($urandom_range(0, 3)), lc);
            end
            if ($urandom_range(0, 7) == 0) begin
                repeat ($urandom_range(1, 3)) begin
                    idx = loaded_idx[$urandom_range(0, loaded_idx.size() - 1)];
                    cand_pixel(idx[PIX_IDX_W-1:0], COLOR_W'($urandom), ID_W'($urandom),
                               1'b0, logic'($urandom_range(0, 1)));
                end
                need_load = 1'b1;
            end
            groups++;
        end

        wait_drained();
        if (tracker.mismatches == 0)
            $display("[edge_row_ssd_top3_match] OK");
        else
            $display("[edge_row_ssd_top3_match] ERROR");
        $finish;
    end

    // Hard stop, many times the slowest legal run.
    initial begin
        #4_000_000;
        $display("[edge_row_ssd_top3_match] ERROR");
        $finish;
    end

endmodule

FILE: files.f
design/ers_pkg.sv
design/ers_ram.sv
design/ers_cost.sv
design/ers_rank_cell.sv
design/edge_row_ssd_top3_match.sv
dv/tb_top.sv
